FILE: hdl/pqp4_pkg.sv
// ----------------------------------------------------------------------------
// pqp4_pkg
// Shared types and constants for the nearest palette color quantizer that
// packs two 3-bit indexes into one byte.
// ----------------------------------------------------------------------------
package pqp4_pkg;

  // palette storage is always eight entries wide
  localparam int NUM_ENTRIES = 8;
  localparam int IDX_W       = 3;
  localparam int COLOR_W     = 24;
  localparam int CHAN_W      = 8;
  // three squared 8-bit differences: 3 * 255^2 fits in 18 bits
  localparam int DIST_W      = 18;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [DIST_W-1:0]  dist_t;

  typedef color_t [NUM_ENTRIES-1:0] palette_t;
  typedef dist_t  [NUM_ENTRIES-1:0] dist_vec_t;

  // input beat payload
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  // output beat payload
  typedef struct packed {
    logic [7:0] packed_byte;
  } result_t;

  // distance stage contents
  typedef struct packed {
    logic      valid;
    dist_vec_t dists;
  } dist_beat_t;

  // pack stage status toward the pipeline control
  typedef struct packed {
    logic take;        // output register can load this cycle
    logic have_first;  // first pixel of a pair is held
  } pack_status_t;

  // palette colors after reset
  localparam palette_t PALETTE_RESET = '{
    24'hC2A4F4, 24'hE87E00, 24'hFFF338, 24'hBF0000,
    24'h6440FF, 24'h438A1C, 24'hFFFFFF, 24'h000000
  };

endpackage

FILE: hdl/pqp4_stream_if.sv
// ----------------------------------------------------------------------------
// pqp4_stream_if
// Valid/ready stream channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface pqp4_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/pqp4_palette_regs.sv
// ----------------------------------------------------------------------------
// pqp4_palette_regs
// Eight 24-bit palette color registers behind a plain write port.
// ----------------------------------------------------------------------------
module pqp4_palette_regs
  import pqp4_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  idx_t     cfg_addr,
  input  color_t   cfg_wdata,
  output palette_t palette
);

  palette_t palette_r;

  // register writes, reset to the default table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_r <= PALETTE_RESET;
    end else if (cfg_we) begin
      palette_r[cfg_addr] <= cfg_wdata;
    end
  end

  assign palette = palette_r;

endmodule

FILE: hdl/pqp4_dist_stage.sv
// ----------------------------------------------------------------------------
// pqp4_dist_stage
// Squared Euclidean distance from the pixel to each active palette color,
// one unit per entry, registered.
// ----------------------------------------------------------------------------
module pqp4_dist_stage
  import pqp4_pkg::*;
#(
  parameter int PALETTE_SIZE = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  logic       pix_valid,
  input  pixel_t     pix,
  input  palette_t   palette,
  output dist_beat_t beat
);

  logic      valid_r;
  dist_vec_t dist_r;
  dist_vec_t dist_nxt;

  function automatic logic [15:0] sq_diff(input chan_t a, input chan_t b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

  // one distance unit per active entry, unused entries read as zero
  for (genvar p = 0; p < NUM_ENTRIES; p++) begin : g_unit
    if (p < PALETTE_SIZE) begin : g_act
      assign dist_nxt[p] = DIST_W'(sq_diff(pix.red,   palette[p][23:16]))
                         + DIST_W'(sq_diff(pix.green, palette[p][15:8]))
                         + DIST_W'(sq_diff(pix.blue,  palette[p][7:0]));
    end else begin : g_off
      assign dist_nxt[p] = '0;
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= pix_valid;
    end
  end

  // distance registers
  always_ff @(posedge clk) begin
    if (load) begin
      dist_r <= dist_nxt;
    end
  end

  assign beat.valid = valid_r;
  assign beat.dists = dist_r;

endmodule

FILE: hdl/pqp4_pack_stage.sv
// ----------------------------------------------------------------------------
// pqp4_pack_stage
// Picks the nearest palette index, pairs pixels and drives the output
// register of the result channel.
// ----------------------------------------------------------------------------
module pqp4_pack_stage
  import pqp4_pkg::*;
#(
  parameter int PALETTE_SIZE = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  dist_beat_t   beat,
  output pack_status_t status,
  pqp4_stream_if.source out_ch
);

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       have_first_r;
  idx_t       held_idx_r;
  logic       take;
  idx_t       best_idx;
  dist_t      best_dist;

  // lowest index wins on equal distance
  always_comb begin
    best_idx  = '0;
    best_dist = beat.dists[0];
    for (int p = 1; p < PALETTE_SIZE; p++) begin
      if (beat.dists[p] < best_dist) begin
        best_dist = beat.dists[p];
        best_idx  = IDX_W'(p);
      end
    end
  end

  // output register is free or being drained
  assign take = !out_valid_r || out_ch.ready;

  // pairing state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      have_first_r <= 1'b0;
      held_idx_r   <= '0;
    end else if (take) begin
      out_valid_r <= beat.valid && have_first_r;
      if (beat.valid) begin
        have_first_r <= !have_first_r;
        if (!have_first_r) begin
          held_idx_r <= best_idx;
        end
      end
    end
  end

  // packed byte: held index high, current index low
  always_ff @(posedge clk) begin
    if (take) begin
      out_byte_r <= {1'b0, held_idx_r, 1'b0, best_idx};
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.data.packed_byte = out_byte_r;
  assign status.take             = take;
  assign status.have_first       = have_first_r;

endmodule

FILE: hdl/palette_quantize_pack4.sv
// ----------------------------------------------------------------------------
// palette_quantize_pack4
// Nearest palette color quantizer with two 3-bit indexes packed per byte.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one RGB888 pixel per beat, out_ch one packed byte per beat.
//   The first pixel of each pair is only held; the second emits a byte with
//   the first pixel's palette index in bits 7..4 and its own in bits 3..0.
//   The palette is written through cfg_we / cfg_addr / cfg_wdata while the
//   block is idle; only the first PALETTE_SIZE entries take part in the search.
// Timing:
//   Three register stages: input register, distance registers (eight
//   parallel distance units), output register. out_ch.valid rises once the
//   second pixel of its pair has passed the distance and output registers.
//   One pixel is accepted every cycle unless out_ch stalls a full pipeline.
// Reset:
//   Palette returns to the default eight-color table, the pair state is
//   cleared and all stages empty.
// Stall:
//   When out_ch is not ready the stages fill up; in_ch.ready drops only once
//   every stage holds a beat.
// ----------------------------------------------------------------------------
module palette_quantize_pack4
  import pqp4_pkg::*;
#(
  parameter int PALETTE_SIZE = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  idx_t          cfg_addr,
  input  color_t        cfg_wdata,
  pqp4_stream_if.sink   in_ch,
  pqp4_stream_if.source out_ch
);

  palette_t     palette;
  dist_beat_t   dist_beat;
  pack_status_t pack_st;
  logic         s1_valid_r;
  pixel_t       pix_r;
  logic         s1_adv;
  logic         s2_adv;

  // pipeline advance, bubbles collapse
  assign s2_adv      = !dist_beat.valid || pack_st.take;
  assign s1_adv      = !s1_valid_r || s2_adv;
  assign in_ch.ready = s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pix_r <= in_ch.data;
    end
  end

  pqp4_palette_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .palette  (palette)
  );

  pqp4_dist_stage #(
    .PALETTE_SIZE(PALETTE_SIZE)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (s2_adv),
    .pix_valid(s1_valid_r),
    .pix      (pix_r),
    .palette  (palette),
    .beat     (dist_beat)
  );

  pqp4_pack_stage #(
    .PALETTE_SIZE(PALETTE_SIZE)
  ) u_pack (
    .clk   (clk),
    .rst_n (rst_n),
    .beat  (dist_beat),
    .status(pack_st),
    .out_ch(out_ch)
  );

  // input stalls only with every stage full and the output blocked
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && dist_beat.valid && out_ch.valid && !out_ch.ready))
    else $error("input stalled with a free stage");

  // pair state flips on every pixel leaving the distance stage
  a_pair_flip: assert property (@(posedge clk) disable iff (!rst_n)
    (pack_st.take && dist_beat.valid) |=> (pack_st.have_first != $past(pack_st.have_first)))
    else $error("pair state did not toggle");

  // a new byte only comes from the second pixel of a pair
  a_out_second: assert property (@(posedge clk) disable iff (!rst_n)
    (pack_st.take && out_ch.valid == 1'b0 && !(dist_beat.valid && pack_st.have_first))
      |=> !out_ch.valid)
    else $error("byte emitted without a completed pair");

  // index nibbles stay within three bits
  a_nibble: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.packed_byte[7] == 1'b0 && out_ch.data.packed_byte[3] == 1'b0))
    else $error("packed byte index out of range");

endmodule

FILE: tb/tb_palette_quantize_pack4.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_palette_quantize_pack4
// Self-checking bench for the nearest palette color quantizer with 4-bit
// index packing. A short table of directed pixels runs first, then phases of
// random pixels under different palettes. Every accepted pixel goes through a
// local nearest-color model, and each packed byte from the block is checked
// against the oldest predicted byte. Both channel ends insert random gaps.
// ----------------------------------------------------------------------------
module tb_palette_quantize_pack4
  import pqp4_pkg::*;
();

  localparam int PAL_SIZE   = 8;
  localparam int NUM_PHASES = 7;
  localparam int MAX_GAP    = 18;
  localparam int SETTLE_CYC = 8;
  localparam int NUM_ROWS   = 26;

  // palette table selectors for the directed rows
  localparam logic [1:0] PAL_DEFAULT = 2'd0;
  localparam logic [1:0] PAL_ZERO    = 2'd1;
  localparam logic [1:0] PAL_DUP     = 2'd2;

  typedef struct packed {
    logic [1:0] pal;
    pixel_t     px;
    logic       typed;
    logic [7:0] want;
  } pix_row_t;

  logic   clk;
  logic   rst_n;
  logic   cfg_we;
  idx_t   cfg_addr;
  color_t cfg_wdata;

  pqp4_stream_if #(.T(pixel_t))  in_ch ();
  pqp4_stream_if #(.T(result_t)) out_ch ();

  palette_quantize_pack4 #(
    .PALETTE_SIZE(PAL_SIZE)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // palette model, pair state and predicted bytes
  color_t      pal_model [NUM_ENTRIES];
  color_t      next_pal  [NUM_ENTRIES];
  idx_t        held_idx;
  bit          held_valid;
  logic [7:0]  byte_q [$];
  int          mismatches;
  bit          no_idle;

  // color table the block starts from after reset
  localparam color_t DEFAULT_PAL [NUM_ENTRIES] = '{
    24'h000000, 24'hFFFFFF, 24'h438A1C, 24'h6440FF,
    24'hBF0000, 24'hFFF338, 24'hE87E00, 24'hC2A4F4
  };

  // palette with repeated colors to exercise the lowest-index tie rule
  localparam color_t DUP_PAL [NUM_ENTRIES] = '{
    24'h101010, 24'h808080, 24'h808080, 24'hF0F0F0,
    24'hF0F0F0, 24'h101010, 24'h000000, 24'hFFFFFF
  };

  // directed pixels; typed bytes are exact hits on palette colors or ties
  pix_row_t dir_rows [NUM_ROWS] = '{
    '{PAL_DEFAULT, 24'h000000, 1'b0, 8'h00},
    '{PAL_DEFAULT, 24'hFFFFFF, 1'b1, 8'h01},
    '{PAL_DEFAULT, 24'hFFFFFF, 1'b0, 8'h00},
    '{PAL_DEFAULT, 24'h000000, 1'b1, 8'h10},
    '{PAL_DEFAULT, 24'hBF0000, 1'b0, 8'h00},
    '{PAL_DEFAULT, 24'hC2A4F4, 1'b1, 8'h47},
    '{PAL_DEFAULT, 24'h438A1C, 1'b0, 8'h00},
    '{PAL_DEFAULT, 24'h6440FF, 1'b1, 8'h23},
    '{PAL_DEFAULT, 24'hFFF338, 1'b0, 8'h00},
    '{PAL_DEFAULT, 24'hE87E00, 1'b1, 8'h56},
    '{PAL_DEFAULT, 24'hFF0000, 1'b0, 8'h00},
    '{PAL_DEFAULT, 24'h00FF00, 1'b0, 8'h00},
    '{PAL_DEFAULT, 24'h0000FF, 1'b0, 8'h00},
    '{PAL_DEFAULT, 24'h808080, 1'b0, 8'h00},
    '{PAL_DEFAULT, 24'h00FFFF, 1'b0, 8'h00},
    '{PAL_DEFAULT, 24'hFF00FF, 1'b0, 8'h00},
    '{PAL_ZERO,    24'hFFFFFF, 1'b0, 8'h00},
    '{PAL_ZERO,    24'h000000, 1'b1, 8'h00},
    '{PAL_ZERO,    24'h123456, 1'b0, 8'h00},
    '{PAL_ZERO,    24'hFF00FF, 1'b1, 8'h00},
    '{PAL_DUP,     24'h808080, 1'b0, 8'h00},
    '{PAL_DUP,     24'h101010, 1'b1, 8'h10},
    '{PAL_DUP,     24'h484848, 1'b0, 8'h00},
    '{PAL_DUP,     24'hF0F0F0, 1'b1, 8'h03},
    '{PAL_DUP,     24'h000000, 1'b0, 8'h00},
    '{PAL_DUP,     24'hFFFFFF, 1'b1, 8'h67}
  };

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int unsigned sq_diff(chan_t a, chan_t b);
    int unsigned d;
    d = (a > b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  // nearest active palette entry, lowest index on equal distance
  function automatic idx_t nearest_entry(pixel_t px);
    int unsigned best_d;
    int unsigned d;
    idx_t        best;
    best   = '0;
    best_d = 0;
    for (int p = 0; p < PAL_SIZE; p++) begin
      d = sq_diff(px.red,   pal_model[p][23:16])
        + sq_diff(px.green, pal_model[p][15:8])
        + sq_diff(px.blue,  pal_model[p][7:0]);
      if (p == 0 || d < best_d) begin
        best_d = d;
        best   = idx_t'(p);
      end
    end
    return best;
  endfunction

  // advance the pair state for one accepted pixel
  task automatic quantize_pixel(pixel_t px, bit typed, logic [7:0] want);
    idx_t idx;
    idx = nearest_entry(px);
    if (!held_valid) begin
      held_idx   = idx;
      held_valid = 1'b1;
    end else begin
      byte_q.push_back(typed ? want : {1'b0, held_idx, 1'b0, idx});
      held_valid = 1'b0;
    end
  endtask

  // drive one pixel beat after a random gap and wait for its acceptance
  task automatic send_pixel(pixel_t px, bit typed, logic [7:0] want);
    int gap;
    @(negedge clk);
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= pixel_t'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= px;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    quantize_pixel(px, typed, want);
  endtask

  // stop sending, let every predicted byte arrive and the pipe empty out
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (byte_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // write all eight palette registers from next_pal
  task automatic write_palette();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      @(negedge clk);
      cfg_we       <= 1'b1;
      cfg_addr     <= idx_t'(i);
      cfg_wdata    <= next_pal[i];
      pal_model[i]  = next_pal[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // channel values lean toward the extremes
  function automatic chan_t rand_chan();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return chan_t'($urandom);
    endcase
  endfunction

  function automatic chan_t near_chan(chan_t c);
    int v;
    v = int'(c) + $urandom_range(0, 6) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return chan_t'(v);
  endfunction

  // random pixel: near a palette color, between two colors, extreme or free
  function automatic pixel_t rand_pixel();
    pixel_t px;
    color_t a;
    color_t b;
    a = pal_model[$urandom_range(0, PAL_SIZE - 1)];
    b = pal_model[$urandom_range(0, PAL_SIZE - 1)];
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        px.red   = near_chan(a[23:16]);
        px.green = near_chan(a[15:8]);
        px.blue  = near_chan(a[7:0]);
      end
      4: begin
        px.red   = chan_t'((int'(a[23:16]) + int'(b[23:16])) / 2);
        px.green = chan_t'((int'(a[15:8]) + int'(b[15:8])) / 2);
        px.blue  = chan_t'((int'(a[7:0]) + int'(b[7:0])) / 2);
      end
      5, 6: begin
        px.red   = rand_chan();
        px.green = rand_chan();
        px.blue  = rand_chan();
      end
      default: px = pixel_t'($urandom);
    endcase
    return px;
  endfunction

  // build the palette for one random phase
  task automatic pick_palette(int ph);
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      case (ph)
        0:       next_pal[i] = DEFAULT_PAL[i];
        1:       next_pal[i] = 24'hFFFFFF;
        2:       next_pal[i] = {{8{i[2]}}, {8{i[1]}}, {8{i[0]}}};
        default: begin
          if (i > 0 && $urandom_range(0, 3) == 0)
            next_pal[i] = next_pal[$urandom_range(0, i - 1)];
          else if ($urandom_range(0, 1) == 0)
            next_pal[i] = {rand_chan(), rand_chan(), rand_chan()};
          else
            next_pal[i] = color_t'($urandom);
        end
      endcase
    end
  endtask

  // result side: random stalls on ready
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  // compare each result beat with the oldest predicted byte
  always @(posedge clk) begin
    logic [7:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (byte_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected byte %02h at %0t", out_ch.data.packed_byte, $realtime);
        mismatches++;
      end else begin
        want = byte_q.pop_front();
        if (out_ch.data.packed_byte !== want) begin
          if (mismatches < 10)
            $display("packed_byte mismatch: expected %02h got %02h at %0t",
                     want, out_ch.data.packed_byte, $realtime);
          mismatches++;
        end
      end
    end
  end

  // main sequence
  initial begin
    logic [1:0] cur_pal;
    int         n_items;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    no_idle     = 1'b0;
    mismatches  = 0;
    held_idx    = '0;
    held_valid  = 1'b0;
    for (int i = 0; i < NUM_ENTRIES; i++) pal_model[i] = DEFAULT_PAL[i];
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table, palette switched only while idle
    cur_pal = PAL_DEFAULT;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (dir_rows[r].pal != cur_pal) begin
        wait_idle();
        for (int i = 0; i < NUM_ENTRIES; i++)
          next_pal[i] = (dir_rows[r].pal == PAL_ZERO) ? 24'h000000 : DUP_PAL[i];
        write_palette();
        cur_pal = dir_rows[r].pal;
      end
      send_pixel(dir_rows[r].px, dir_rows[r].typed, dir_rows[r].want);
    end

    // random phases; odd pixel counts carry a held pixel across a rewrite
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      pick_palette(ph);
      write_palette();
      no_idle = (ph == 3);
      n_items = $urandom_range(150, 190);
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 59) == 0) wait_idle();
        send_pixel(rand_pixel(), 1'b0, 8'h00);
      end
      no_idle = 1'b0;
    end

    // drain and finish
    wait_idle();
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0 && byte_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
